// File: design/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, word types and constants shared by the 3x3 adjugate inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int FRAC_BITS = 16;
   localparam int W         = 32;
   localparam int PW        = 2 * W;
   localparam int CW        = PW + 1;
   localparam int PPW       = 2 * W + 1;
   localparam int DPW       = W + CW;
   localparam int DW        = DPW + 2;
   localparam int MW        = DW - 1;
   localparam int QBITS     = W;
   localparam int RW        = MW + QBITS;
   localparam int NUM_SHIFT = 2 * FRAC_BITS;
   localparam int CN        = 9;
   localparam int DN        = 3;
   localparam int DIV_LAT   = QBITS + 3;
   localparam int LAT       = 7 + DIV_LAT;

   localparam logic [MW-1:0] SING_THR = MW'(1) << (3 * FRAC_BITS - 23);

   typedef struct packed {
      logic signed [W-1:0] a11;
      logic signed [W-1:0] a12;
      logic signed [W-1:0] a13;
      logic signed [W-1:0] a21;
      logic signed [W-1:0] a22;
      logic signed [W-1:0] a23;
      logic signed [W-1:0] a31;
      logic signed [W-1:0] a32;
      logic signed [W-1:0] a33;
   } req_word_type;

   typedef struct packed {
      logic signed [W-1:0] r11;
      logic signed [W-1:0] r12;
      logic signed [W-1:0] r13;
      logic signed [W-1:0] r21;
      logic signed [W-1:0] r22;
      logic signed [W-1:0] r23;
      logic signed [W-1:0] r31;
      logic signed [W-1:0] r32;
      logic signed [W-1:0] r33;
      logic                singular;
      logic                saturated;
   } rsp_word_type;

endpackage

// File: design/mi3_cofactor_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cofactor_lane
// Signed cofactor x0*x1 - x2*x3; two products, then the difference.
// ----------------------------------------------------------------------------
module mi3_cofactor_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [mi3_pkg::W-1:0]  x0,
   input  logic signed [mi3_pkg::W-1:0]  x1,
   input  logic signed [mi3_pkg::W-1:0]  x2,
   input  logic signed [mi3_pkg::W-1:0]  x3,
   output logic signed [mi3_pkg::CW-1:0] cof
);
   import mi3_pkg::*;

   logic signed [PW-1:0] p0_in, p1_in, p0_ff, p1_ff;
   logic signed [CW-1:0] cof_in, cof_ff;

   always_comb begin
      p0_in  = PW'(x0) * PW'(x1);
      p1_in  = PW'(x2) * PW'(x3);
      cof_in = CW'(p0_ff) - CW'(p1_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         cof_ff <= cof_in;
      end
   end

   assign cof = cof_ff;

endmodule

// File: design/mi3_det_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det_lane
// One determinant term: element times cofactor, split in two partial products.
// ----------------------------------------------------------------------------
module mi3_det_lane (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [mi3_pkg::W-1:0]   a,
   input  logic signed [mi3_pkg::CW-1:0]  cof,
   output logic signed [mi3_pkg::DPW-1:0] prod
);
   import mi3_pkg::*;

   logic signed [PPW-1:0] plo_in, phi_in, plo_ff, phi_ff;
   logic signed [DPW-1:0] prod_in, prod_ff;

   always_comb begin
      plo_in  = PPW'(a) * PPW'($signed({1'b0, cof[W-1:0]}));
      phi_in  = PPW'(a) * PPW'($signed(cof[CW-1:W]));
      prod_in = (DPW'(phi_ff) <<< W) + DPW'(plo_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// File: design/mi3_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divide of a scaled cofactor by |det|, one quotient bit
// per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module mi3_div_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [mi3_pkg::CW-1:0] cof,
   input  logic        [mi3_pkg::MW-1:0] mag,
   input  logic                          dneg,
   output logic signed [mi3_pkg::W-1:0]  res,
   output logic                          sat
);
   import mi3_pkg::*;

   localparam logic [QBITS-1:0] MIN_Q = {1'b1, (QBITS-1)'(0)};
   localparam logic [QBITS-1:0] MAX_Q = MIN_Q - 1'b1;

   logic [CW-1:0]    cmag;
   logic [RW-1:0]    num_a_in, num_a_ff;
   logic [MW-1:0]    mag_a_ff;
   logic             neg_a_in, neg_a_ff;

   logic [RW-1:0]    rem_in [QBITS];
   logic [RW-1:0]    rem_ff [QBITS];
   logic [QBITS-1:0] quo_in [QBITS+1];
   logic [QBITS-1:0] quo_ff [QBITS+1];
   logic [MW-1:0]    mag_ff [QBITS];
   logic             neg_ff [QBITS+1];
   logic             ovf_ff [QBITS+1];
   logic             ovf_in;

   logic signed [W-1:0] res_in, res_ff;
   logic                sat_in, sat_ff;
   logic [RW-1:0]       sub;
   logic                ge;
   logic [QBITS-1:0]    q;

   always_comb begin
      cmag     = cof[CW-1] ? CW'(-cof) : CW'(cof);
      num_a_in = RW'(cmag) << NUM_SHIFT;
      neg_a_in = cof[CW-1] ^ dneg;
      ovf_in   = num_a_ff >= {mag_a_ff, QBITS'(0)};
      rem_in[0] = num_a_ff;
      quo_in[0] = '0;
      for (int j = 1; j <= QBITS; j++) begin
         sub = RW'(mag_ff[j-1]) << (QBITS - j);
         ge  = rem_ff[j-1] >= sub;
         quo_in[j] = quo_ff[j-1] | (ge ? (QBITS'(1) << (QBITS - j)) : QBITS'(0));
         if (j < QBITS) begin
            rem_in[j] = ge ? (rem_ff[j-1] - sub) : rem_ff[j-1];
         end
      end
      q = quo_ff[QBITS];
      if (neg_ff[QBITS]) begin
         if (ovf_ff[QBITS] || q > MIN_Q) begin
            res_in = $signed(MIN_Q);
            sat_in = 1'b1;
         end else begin
            res_in = $signed(QBITS'(0) - q);
            sat_in = 1'b0;
         end
      end else begin
         if (ovf_ff[QBITS] || q > MAX_Q) begin
            res_in = $signed(MAX_Q);
            sat_in = 1'b1;
         end else begin
            res_in = $signed(q);
            sat_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_a_ff  <= num_a_in;
         mag_a_ff  <= mag;
         neg_a_ff  <= neg_a_in;
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         mag_ff[0] <= mag_a_ff;
         neg_ff[0] <= neg_a_ff;
         ovf_ff[0] <= ovf_in;
         for (int j = 1; j <= QBITS; j++) begin
            quo_ff[j] <= quo_in[j];
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            if (j < QBITS) begin
               rem_ff[j] <= rem_in[j];
               mag_ff[j] <= mag_ff[j-1];
            end
         end
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign res = res_ff;
   assign sat = sat_ff;

endmodule

// File: design/matrix3_inverse_adjugate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate_core
// 3x3 inverse in signed fixed point by adjugate over determinant.
//
//   channel   dir   handshake            word
//   req       in    req_valid/req_stall  req_word_type  (a11..a33)
//   rsp       out   rsp_valid/rsp_stall  rsp_word_type  (r11..r33, flags)
//
// One matrix per clock while the skid register is empty; each of nine lanes ends in
// a restoring divider with 32 quotient-bit stages.
// Reset clears the valid bits of the pipeline, the output register and the
// skid register.
// A stalled output word holds; the next word parks in a skid register and the
// pipeline freezes only while that skid register is full.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mi3_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mi3_pkg::rsp_word_type rsp_word
);
   import mi3_pkg::*;

   localparam int OPX [CN][4] = '{
      '{4, 8, 7, 5}, '{6, 5, 3, 8}, '{3, 7, 6, 4},
      '{7, 2, 1, 8}, '{0, 8, 6, 2}, '{6, 1, 0, 7},
      '{1, 5, 4, 2}, '{3, 2, 0, 5}, '{0, 4, 3, 1}
   };

   logic                en;
   logic                v_ff   [LAT];
   req_word_type        mat_ff [LAT];
   logic signed [W-1:0] m      [CN];
   logic signed [W-1:0] row0   [DN];

   logic signed [CW-1:0]  cof_w   [CN];
   logic signed [CW-1:0]  cofd_ff [4][CN];
   logic signed [DPW-1:0] prod_w  [DN];
   logic signed [DW-1:0]  det_in, det_ff;
   logic        [MW-1:0]  mag_in, mag_ff;
   logic                  dneg_ff;
   logic                  sgl_in;
   logic                  sgl_ff  [DIV_LAT+1];
   logic signed [W-1:0]   res_w   [CN];
   logic                  sat_w   [CN];

   rsp_word_type tail_word;
   rsp_word_type out_ff, skid_ff;
   logic         out_v_ff, skid_v_ff;
   logic         take;
   logic         any_sat;

   assign en   = !skid_v_ff;
   assign take = out_v_ff && !rsp_stall;

   always_comb begin
      m[0] = mat_ff[0].a11;
      m[1] = mat_ff[0].a12;
      m[2] = mat_ff[0].a13;
      m[3] = mat_ff[0].a21;
      m[4] = mat_ff[0].a22;
      m[5] = mat_ff[0].a23;
      m[6] = mat_ff[0].a31;
      m[7] = mat_ff[0].a32;
      m[8] = mat_ff[0].a33;
      row0[0] = mat_ff[2].a11;
      row0[1] = mat_ff[2].a12;
      row0[2] = mat_ff[2].a13;
   end

   for (genvar c = 0; c < CN; c++) begin : g_cof
      mi3_cofactor_lane u_cof (
         .clock (clock),
         .en    (en),
         .x0    (m[OPX[c][0]]),
         .x1    (m[OPX[c][1]]),
         .x2    (m[OPX[c][2]]),
         .x3    (m[OPX[c][3]]),
         .cof   (cof_w[c])
      );
   end

   for (genvar d = 0; d < DN; d++) begin : g_det
      mi3_det_lane u_det (
         .clock (clock),
         .en    (en),
         .a     (row0[d]),
         .cof   (cof_w[d]),
         .prod  (prod_w[d])
      );
   end

   always_comb begin
      det_in = DW'(prod_w[0]) + DW'(prod_w[1]) + DW'(prod_w[2]);
      mag_in = det_ff[DW-1] ? MW'(-det_ff) : MW'(det_ff);
      sgl_in = mag_in <= SING_THR;
   end

   for (genvar k = 0; k < CN; k++) begin : g_div
      mi3_div_lane u_div (
         .clock (clock),
         .en    (en),
         .cof   (cofd_ff[3][k]),
         .mag   (mag_ff),
         .dneg  (dneg_ff),
         .res   (res_w[k]),
         .sat   (sat_w[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff[0] <= req_word;
         for (int i = 1; i < LAT; i++) begin
            mat_ff[i] <= mat_ff[i-1];
         end
         cofd_ff[0] <= cof_w;
         for (int i = 1; i < 4; i++) begin
            cofd_ff[i] <= cofd_ff[i-1];
         end
         det_ff    <= det_in;
         mag_ff    <= mag_in;
         dneg_ff   <= det_ff[DW-1];
         sgl_ff[0] <= sgl_in;
         for (int i = 1; i <= DIV_LAT; i++) begin
            sgl_ff[i] <= sgl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // merge lanes: lane k holds cofactor (k/3, k%3), which lands transposed; singular input passes through
   always_comb begin
      any_sat = 1'b0;
      for (int k = 0; k < CN; k++) begin
         any_sat = any_sat | sat_w[k];
      end
      if (sgl_ff[DIV_LAT]) begin
         tail_word.r11 = mat_ff[LAT-1].a11;
         tail_word.r12 = mat_ff[LAT-1].a12;
         tail_word.r13 = mat_ff[LAT-1].a13;
         tail_word.r21 = mat_ff[LAT-1].a21;
         tail_word.r22 = mat_ff[LAT-1].a22;
         tail_word.r23 = mat_ff[LAT-1].a23;
         tail_word.r31 = mat_ff[LAT-1].a31;
         tail_word.r32 = mat_ff[LAT-1].a32;
         tail_word.r33 = mat_ff[LAT-1].a33;
         tail_word.singular  = 1'b1;
         tail_word.saturated = 1'b0;
      end else begin
         tail_word.r11 = res_w[0];
         tail_word.r12 = res_w[3];
         tail_word.r13 = res_w[6];
         tail_word.r21 = res_w[1];
         tail_word.r22 = res_w[4];
         tail_word.r23 = res_w[7];
         tail_word.r31 = res_w[2];
         tail_word.r32 = res_w[5];
         tail_word.r33 = res_w[8];
         tail_word.singular  = 1'b0;
         tail_word.saturated = any_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (en) begin
         if (v_ff[LAT-1]) begin
            if (!out_v_ff || take) begin
               out_ff   <= tail_word;
               out_v_ff <= 1'b1;
            end else begin
               skid_ff   <= tail_word;
               skid_v_ff <= 1'b1;
            end
         end else if (take) begin
            out_v_ff <= 1'b0;
         end
      end else if (take) begin
         out_ff    <= skid_ff;
         skid_v_ff <= 1'b0;
      end
   end

   assign req_stall = skid_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid word held with empty output register");

   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (en && v_ff[LAT-1] && out_v_ff && !take) |=> skid_v_ff)
      else $error("tail word dropped while output stalled");

   a_singular_flags: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.singular) |-> !out_ff.saturated)
      else $error("singular word reports saturation");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && take) |=> (out_v_ff && !skid_v_ff))
      else $error("skid word not moved on take");

endmodule

// File: tb/matrix3_inverse_adjugate_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate_core_tb
// Drives random and corner 3x3 Q16.16 matrices through the inverse core with
// bursty input and patterned output stall, predicts each inverse with exact
// wide arithmetic, and checks every output word in order.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate_core_tb;
   import mi3_pkg::*;

   localparam int RANDOM_N  = 1650;
   localparam int WDOG_MAX  = 4000;

   class inverse_scoreboard;
      rsp_word_type pending[$];
      int           errors;

      function automatic rsp_word_type predict_inverse(req_word_type a);
         logic signed [127:0] m[3][3];
         logic signed [127:0] cof[3][3];
         logic signed [127:0] det, mag, num, q;
         logic signed [31:0]  v[9];
         logic                neg, sat;
         rsp_word_type        r;
         int                  r0, r1, c0, c1;
         m[0][0] = a.a11; m[0][1] = a.a12; m[0][2] = a.a13;
         m[1][0] = a.a21; m[1][1] = a.a22; m[1][2] = a.a23;
         m[2][0] = a.a31; m[2][1] = a.a32; m[2][2] = a.a33;
         sat = 1'b0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               r0 = (i == 0) ? 1 : 0; r1 = (i == 2) ? 1 : 2;
               c0 = (j == 0) ? 1 : 0; c1 = (j == 2) ? 1 : 2;
               cof[i][j] = m[r0][c0] * m[r1][c1] - m[r1][c0] * m[r0][c1];
               if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
            end
         det = m[0][0] * cof[0][0] + m[0][1] * cof[0][1] + m[0][2] * cof[0][2];
         mag = det < 0 ? -det : det;
         if (mag <= (128'sd1 <<< (3 * FRAC_BITS - 23))) begin
            r = '0;
            r.r11 = a.a11; r.r12 = a.a12; r.r13 = a.a13;
            r.r21 = a.a21; r.r22 = a.a22; r.r23 = a.a23;
            r.r31 = a.a31; r.r32 = a.a32; r.r33 = a.a33;
            r.singular = 1'b1;
            return r;
         end
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               num = cof[j][i];
               neg = (num < 0) != (det < 0);
               if (num < 0) num = -num;
               num = num <<< (2 * FRAC_BITS);
               q = $unsigned(num) / $unsigned(mag);
               if (neg) begin
                  if (q > 128'sh80000000) begin
                     v[i*3+j] = 32'h80000000; sat = 1'b1;
                  end else v[i*3+j] = -q[31:0];
               end else begin
                  if (q > 128'sh7FFFFFFF) begin
                     v[i*3+j] = 32'h7FFFFFFF; sat = 1'b1;
                  end else v[i*3+j] = q[31:0];
               end
            end
         r.r11 = v[0]; r.r12 = v[1]; r.r13 = v[2];
         r.r21 = v[3]; r.r22 = v[4]; r.r23 = v[5];
         r.r31 = v[6]; r.r32 = v[7]; r.r33 = v[8];
         r.singular = 1'b0;
         r.saturated = sat;
         return r;
      endfunction

      function void note_matrix(req_word_type a);
         pending.push_back(predict_inverse(a));
      endfunction

      function void check_inverse(rsp_word_type got);
         rsp_word_type exp_w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
         end
         exp_w = pending.pop_front();
         if (got !== exp_w) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_w, got);
            if (got.singular !== exp_w.singular)
               $display("%0t:  singular expected %b actual %b", $time,
                        exp_w.singular, got.singular);
            if (got.saturated !== exp_w.saturated)
               $display("%0t:  saturated expected %b actual %b", $time,
                        exp_w.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   inverse_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  timed_out = 1'b0;
   int  stall_mode = 0;

   always #10 clock = ~clock;

   matrix3_inverse_adjugate_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_matrix(req_word);
         if (rsp_valid && !rsp_stall) sb.check_inverse(rsp_word);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern: modes change every so often
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (idle_cycles >= WDOG_MAX && !timed_out) begin
         timed_out = 1'b1;
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [31:0] pick_elem();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'h00000000;
         3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
         4: return $signed($urandom_range(0, 65535)) - 32768;
         5: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_matrix(req_word_type a);
      req_valid <= 1'b1;
      req_word  <= a;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic req_word_type make_diag(logic [31:0] d0, logic [31:0] d1,
                                              logic [31:0] d2);
      req_word_type a;
      a = '0;
      a.a11 = d0; a.a22 = d1; a.a33 = d2;
      return a;
   endfunction

   req_word_type dir_q[$];
   req_word_type w;
   int burst;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_q.push_back(make_diag(32'h00010000, 32'h00010000, 32'h00010000));
      dir_q.push_back(make_diag(32'hFFFF0000, 32'h00020000, 32'h00008000));
      dir_q.push_back('0);
      dir_q.push_back({9{32'h7FFFFFFF}});
      dir_q.push_back({9{32'h80000000}});
      dir_q.push_back(make_diag(32'h00000001, 32'h00000001, 32'h00000001));
      dir_q.push_back(make_diag(32'h00000100, 32'h00000100, 32'h00000100));
      dir_q.push_back(make_diag(32'h00000200, 32'h00000100, 32'h00000100));
      dir_q.push_back(make_diag(32'h00000020, 32'h00000100, 32'h00000100));
      dir_q.push_back(make_diag(32'h00000021, 32'h00000100, 32'h00000100));
      dir_q.push_back(make_diag(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
      dir_q.push_back(make_diag(32'h80000000, 32'h80000000, 32'h80000000));
      dir_q.push_back(make_diag(32'h00001000, 32'h00010000, 32'h00010000));
      dir_q.push_back(make_diag(32'hFFFFF000, 32'h00010000, 32'h00010000));
      dir_q.push_back(make_diag(32'h00000002, 32'h00010000, 32'h00010000));
      dir_q.push_back({32'h00010000, 32'h00020000, 32'h00030000,
                       32'h00040000, 32'h00050000, 32'h00060000,
                       32'h00070000, 32'h00080000, 32'h000A0000});
      dir_q.push_back({32'h00010000, 32'h00020000, 32'h00030000,
                       32'h00020000, 32'h00040000, 32'h00060000,
                       32'h00070000, 32'h00080000, 32'h00090000});
      dir_q.push_back({32'h80000000, 32'h7FFFFFFF, 32'h00000000,
                       32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                       32'h00000000, 32'h00010000, 32'h80000000});
      dir_q.push_back({9{32'hFFFFFFFF}});
      dir_q.push_back({9{32'h55555555}});
      foreach (dir_q[i]) begin
         send_matrix(dir_q[i]);
         if ($urandom_range(0, 2) == 0) send_gap();
      end

      for (int n = 0; n < RANDOM_N; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < RANDOM_N; b++, n++) begin
            w = {pick_elem(), pick_elem(), pick_elem(), pick_elem(), pick_elem(),
                 pick_elem(), pick_elem(), pick_elem(), pick_elem()};
            if ($urandom_range(0, 9) == 0) begin
               w.a31 = w.a21; w.a32 = w.a22; w.a33 = w.a23;
            end
            send_matrix(w);
         end
         if ($urandom_range(0, 3) != 0) send_gap();
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2 * LAT) @(posedge clock);
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: matrix3_inverse_adjugate_core.f
design/mi3_pkg.sv
design/mi3_cofactor_lane.sv
design/mi3_det_lane.sv
design/mi3_div_lane.sv
design/matrix3_inverse_adjugate_core.sv
tb/matrix3_inverse_adjugate_core_tb.sv
